FILE: rtl/bcc_pkg.sv
// Shared types and constants for the button chord combo engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcc_pkg;

	localparam int CODE_W     = 10;   // key code width
	localparam int KV_W       = 2;    // key value width
	localparam int CNT_W      = 3;    // combo_count register width
	localparam int RULE_REGS  = 4;    // rule registers present on the config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 30;
	localparam int PEND_W     = 7;    // emit slots: 3 key/sync pairs plus the verdict

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RULE0 = 3'd1;

	// key value codes; anything else is autorepeat
	localparam logic [KV_W-1:0] KV_RELEASE = 2'd0;
	localparam logic [KV_W-1:0] KV_PRESS   = 2'd1;

	typedef enum logic [1:0] {
		KIND_KEY     = 2'd0,
		KIND_SYNC    = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	// same layout as the rule register: target 29:20, second 19:10, first 9:0
	typedef struct packed {
		logic [CODE_W-1:0] tg;
		logic [CODE_W-1:0] b2;
		logic [CODE_W-1:0] b1;
	} rule_t;

	typedef struct packed {
		kind_t             kind;
		logic [CODE_W-1:0] code;
		logic              value;
		logic              fwd;
		logic              last;
	} item_t;

endpackage

`default_nettype wire

FILE: rtl/button_chord_combo_engine_unit.sv
// Top level of the button chord combo engine: config registers, sequencer,
// output register. Depends on bcc_pkg, bcc_engine, bcc_outreg.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready.
//    Index 0 is combo_count (3 bits), 1..4 are rules 0..3 (tg 29:20,
//    second button 19:10, first 9:0). Other indexes are dropped.
//  - Input channel (in_valid/in_ready): one key event per beat, key_code and
//    key_value (0 release, 1 press, 2/3 autorepeat).
//  - Output channel (out_valid/out_ready): per input, zero to three key/sync
//    beat pairs, then one verdict beat with last=1 and forward set when the
//    original event should pass through.
//  - Sequencing: a press scans the rules, one rule per cycle from the held
//    bitmap, then does one virtual bitmap read if a rule fires; a new input
//    is taken the cycle after the verdict leaves the sequencer.
//  - Reset: a clearing pass writes both bitmaps, one entry per cycle, over
//    all KEY_CODES entries (1024 by default); in_ready stays low meanwhile.
//    Config writes are taken during the pass.
//  - Stall: a held result beat waits in the output register; the sequencer
//    stops until the register frees up, so no beat is dropped.
`default_nettype none

module button_chord_combo_engine_unit import bcc_pkg::*; #(
	parameter int MAX_COMBOS = 4,
	parameter int KEY_CODES  = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [CODE_W-1:0]     key_code,
	input  wire logic [KV_W-1:0]       key_value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 item_kind,
	output logic [CODE_W-1:0]          event_code,
	output logic                       event_value,
	output logic                       forward,
	output logic                       last
);

	logic             cfg_fire;
	logic [CNT_W-1:0] combo_count_q;
	logic [CNT_W-1:0] count_eff;
	rule_t            rules [MAX_COMBOS];
	logic             push_valid;
	logic             push_ready;
	item_t            push_item;
	item_t            out_item;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			combo_count_q <= '0;
		end else if (cfg_fire && cfg_index == REG_COUNT) begin
			combo_count_q <= cfg_data[CNT_W-1:0];
		end
	end

	// rule slots past the register list stay zero and are still scanned
	for (genvar r = 0; r < MAX_COMBOS; r++) begin : g_rule
		if (r < RULE_REGS) begin : g_reg
			rule_t rule_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rule_q <= '0;
				end else if (cfg_fire && cfg_index == CFG_IDX_W'(REG_RULE0 + r)) begin
					rule_q <= rule_t'(cfg_data);
				end
			end
			assign rules[r] = rule_q;
		end else begin : g_zero
			assign rules[r] = '0;
		end
	end

	// a count past the rule slots means all slots
	assign count_eff = (32'(combo_count_q) > 32'(MAX_COMBOS)) ?
		CNT_W'(MAX_COMBOS) : combo_count_q;

	bcc_engine #(.MAX_COMBOS(MAX_COMBOS), .KEY_CODES(KEY_CODES)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.key_code   (key_code),
		.key_value  (key_value),
		.count      (count_eff),
		.rules      (rules),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	bcc_outreg u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

	assign item_kind   = out_item.kind;
	assign event_code  = out_item.code;
	assign event_value = out_item.value;
	assign forward     = out_item.fwd;
	assign last        = out_item.last;

endmodule

`default_nettype wire

FILE: rtl/bcc_bitmap.sv
// One-bit-wide key bitmap: one write port, two read ports, registered reads.
// Uses bcc_pkg for nothing beyond the house import convention.
`default_nettype none

module bcc_bitmap import bcc_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] wa,
	input  wire logic          wd,
	input  wire logic [AW-1:0] ra0,
	input  wire logic [AW-1:0] ra1,
	output logic               rd0,
	output logic               rd1
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0 <= mem[ra0];
		rd1 <= mem[ra1];
	end

endmodule

`default_nettype wire

FILE: rtl/bcc_engine.sv
// Combo sequencer: holds the physical and virtual held bitmaps in memories,
// scans the rules, and emits result beats. Depends on bcc_pkg, bcc_bitmap.
`default_nettype none

module bcc_engine import bcc_pkg::*; #(
	parameter int MAX_COMBOS = 4,
	parameter int KEY_CODES  = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [CODE_W-1:0] key_code,
	input  wire logic [KV_W-1:0]   key_value,
	input  wire logic [CNT_W-1:0]  count,
	input  wire rule_t             rules [MAX_COMBOS],
	output logic                   push_valid,
	input  wire logic              push_ready,
	output item_t                  push_item
);

	localparam int AW = $clog2(KEY_CODES);

	// emit slots, lowest first
	localparam int P_REC1    = 0;
	localparam int P_REC2    = 2;
	localparam int P_TGT     = 4;
	localparam int P_VERDICT = 6;
	localparam logic [PEND_W-1:0] PEND_VERDICT = 7'b1000000;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_SCAN,
		S_VRD,
		S_VEV,
		S_REL,
		S_EMIT
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [CODE_W-1:0]   code_q;
	logic [KV_W-1:0]     kv_q;
	logic [CNT_W-1:0]    rd_r_q;
	logic [CNT_W-1:0]    ev_r_s1;
	logic                ev_valid_s1;
	logic [CNT_W-1:0]    fire_r_q;
	logic [CODE_W-1:0]   b1_q;
	logic [CODE_W-1:0]   b2_q;
	logic [CODE_W-1:0]   tg_q;
	logic                tval_q;
	logic                fwd_q;
	logic                ph_we_q;
	logic                ph_wd_q;
	logic                vt_we_q;
	logic                vt_wd_q;
	logic [PEND_W-1:0]   pend_q;
	logic [MAX_COMBOS-1:0] active_q;

	// memory ports
	logic          ph_we, ph_wd, ph_rd0, ph_rd1;
	logic [AW-1:0] ph_wa, ph_ra0, ph_ra1;
	logic          vt_we, vt_wd, vt_rd0, vt_rd1;
	logic [AW-1:0] vt_wa, vt_ra0, vt_ra1;

	rule_t             rd_rule;
	rule_t             ev_rule;
	logic              ev_act;
	logic              hit;
	logic [CNT_W-1:0]  hit_r;
	logic [CODE_W-1:0] hit_tg;
	logic              held1, held2, qualify, scan_last, issue_ok;
	logic              rec1, rec2;
	logic [PEND_W-1:0] lo;
	logic              push_fire;

	function automatic logic in_map(input logic [CODE_W-1:0] c);
		return (32'(c) < 32'(KEY_CODES));
	endfunction

	bcc_bitmap #(.DEPTH(KEY_CODES), .AW(AW)) u_phys (
		.clk (clk),
		.we  (ph_we),
		.wa  (ph_wa),
		.wd  (ph_wd),
		.ra0 (ph_ra0),
		.ra1 (ph_ra1),
		.rd0 (ph_rd0),
		.rd1 (ph_rd1)
	);

	bcc_bitmap #(.DEPTH(KEY_CODES), .AW(AW)) u_virt (
		.clk (clk),
		.we  (vt_we),
		.wa  (vt_wa),
		.wd  (vt_wd),
		.ra0 (vt_ra0),
		.ra1 (vt_ra1),
		.rd0 (vt_rd0),
		.rd1 (vt_rd1)
	);

	// rule selection and the active-rule match used by release and repeat
	always_comb begin
		rd_rule = '0;
		ev_rule = '0;
		ev_act  = 1'b0;
		hit     = 1'b0;
		hit_r   = '0;
		hit_tg  = '0;
		for (int i = 0; i < MAX_COMBOS; i++) begin
			if (CNT_W'(i) == rd_r_q) begin
				rd_rule = rules[i];
			end
			if (CNT_W'(i) == ev_r_s1) begin
				ev_rule = rules[i];
				ev_act  = active_q[i];
			end
		end
		// walk downward so the lowest matching rule wins
		for (int i = MAX_COMBOS - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < count) && active_q[i] &&
			    (code_q == rules[i].b1 || code_q == rules[i].b2)) begin
				hit    = 1'b1;
				hit_r  = CNT_W'(i);
				hit_tg = rules[i].tg;
			end
		end
	end

	// scan evaluation; the pressed key counts as held before its write lands
	assign held1     = in_map(ev_rule.b1) && (ph_rd0 || ev_rule.b1 == code_q);
	assign held2     = in_map(ev_rule.b2) && (ph_rd1 || ev_rule.b2 == code_q);
	assign qualify   = ev_valid_s1 && !ev_act && held1 && held2;
	assign scan_last = (CNT_W'(ev_r_s1 + 1'b1) == count);
	assign issue_ok  = (rd_r_q < count);

	// recall checks; a rule naming one button twice recalls it once
	assign rec1 = in_map(b1_q) && vt_rd0;
	assign rec2 = in_map(b2_q) && vt_rd1 && (b2_q != b1_q);

	assign ph_ra0 = rd_rule.b1[AW-1:0];
	assign ph_ra1 = rd_rule.b2[AW-1:0];
	assign vt_ra0 = (state_q == S_VRD) ? b1_q[AW-1:0] : code_q[AW-1:0];
	assign vt_ra1 = b2_q[AW-1:0];

	assign in_ready   = (state_q == S_IDLE);
	assign push_valid = (state_q == S_EMIT);
	assign push_fire  = push_valid && push_ready;
	assign lo         = pend_q & (~pend_q + 1'b1);

	always_comb begin
		push_item.kind  = KIND_SYNC;
		push_item.code  = '0;
		push_item.value = 1'b0;
		push_item.fwd   = 1'b0;
		push_item.last  = 1'b0;
		if (lo[P_REC1]) begin
			push_item.kind = KIND_KEY;
			push_item.code = b1_q;
		end else if (lo[P_REC2]) begin
			push_item.kind = KIND_KEY;
			push_item.code = b2_q;
		end else if (lo[P_TGT]) begin
			push_item.kind  = KIND_KEY;
			push_item.code  = tg_q;
			push_item.value = tval_q;
		end else if (lo[P_VERDICT]) begin
			push_item.kind = KIND_VERDICT;
			push_item.fwd  = fwd_q;
			push_item.last = 1'b1;
		end
	end

	// bitmap writes: clearing sweep, or one write tied to the beat going out
	always_comb begin
		ph_we = 1'b0;
		ph_wa = code_q[AW-1:0];
		ph_wd = ph_wd_q;
		vt_we = 1'b0;
		vt_wa = code_q[AW-1:0];
		vt_wd = vt_wd_q;
		if (state_q == S_CLEAR) begin
			ph_we = 1'b1;
			ph_wa = clr_q;
			ph_wd = 1'b0;
			vt_we = 1'b1;
			vt_wa = clr_q;
			vt_wd = 1'b0;
		end else if (push_fire) begin
			if (lo[P_REC1]) begin
				vt_we = in_map(b1_q);
				vt_wa = b1_q[AW-1:0];
				vt_wd = 1'b0;
			end else if (lo[P_REC2]) begin
				vt_we = in_map(b2_q);
				vt_wa = b2_q[AW-1:0];
				vt_wd = 1'b0;
			end else if (lo[P_TGT]) begin
				vt_we = in_map(tg_q);
				vt_wa = tg_q[AW-1:0];
				vt_wd = tval_q;
			end else if (lo[P_VERDICT]) begin
				ph_we = ph_we_q && in_map(code_q);
				vt_we = vt_we_q && in_map(code_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			code_q      <= '0;
			kv_q        <= '0;
			rd_r_q      <= '0;
			ev_r_s1     <= '0;
			ev_valid_s1 <= 1'b0;
			fire_r_q    <= '0;
			b1_q        <= '0;
			b2_q        <= '0;
			tg_q        <= '0;
			tval_q      <= 1'b0;
			fwd_q       <= 1'b0;
			ph_we_q     <= 1'b0;
			ph_wd_q     <= 1'b0;
			vt_we_q     <= 1'b0;
			vt_wd_q     <= 1'b0;
			pend_q      <= '0;
			active_q    <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(KEY_CODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						code_q  <= key_code;
						kv_q    <= key_value;
						state_q <= S_START;
					end
				end
				S_START: begin
					if (count == '0) begin
						pend_q  <= PEND_VERDICT;
						fwd_q   <= 1'b1;
						ph_we_q <= 1'b0;
						vt_we_q <= 1'b0;
						state_q <= S_EMIT;
					end else if (kv_q == KV_PRESS) begin
						rd_r_q      <= '0;
						ev_valid_s1 <= 1'b0;
						state_q     <= S_SCAN;
					end else if (kv_q == KV_RELEASE) begin
						state_q <= S_REL;
					end else begin
						// autorepeat: no state change
						pend_q  <= PEND_VERDICT;
						fwd_q   <= !hit;
						ph_we_q <= 1'b0;
						vt_we_q <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_SCAN: begin
					if (issue_ok) begin
						ev_valid_s1 <= 1'b1;
						ev_r_s1     <= rd_r_q;
						rd_r_q      <= rd_r_q + 1'b1;
					end else begin
						ev_valid_s1 <= 1'b0;
					end
					if (qualify) begin
						b1_q     <= ev_rule.b1;
						b2_q     <= ev_rule.b2;
						tg_q     <= ev_rule.tg;
						fire_r_q <= ev_r_s1;
						state_q  <= S_VRD;
					end else if (ev_valid_s1 && scan_last) begin
						// plain press: mark held on both maps and forward
						pend_q  <= PEND_VERDICT;
						fwd_q   <= 1'b1;
						ph_we_q <= 1'b1;
						ph_wd_q <= 1'b1;
						vt_we_q <= 1'b1;
						vt_wd_q <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_VRD: begin
					state_q <= S_VEV;
				end
				S_VEV: begin
					pend_q  <= {1'b1, 1'b1, 1'b1, rec2, rec2, rec1, rec1};
					tval_q  <= 1'b1;
					fwd_q   <= 1'b0;
					ph_we_q <= 1'b1;
					ph_wd_q <= 1'b1;
					vt_we_q <= 1'b0;
					for (int i = 0; i < MAX_COMBOS; i++) begin
						if (CNT_W'(i) == fire_r_q) begin
							active_q[i] <= 1'b1;
						end
					end
					state_q <= S_EMIT;
				end
				S_REL: begin
					ph_we_q <= 1'b1;
					ph_wd_q <= 1'b0;
					if (hit) begin
						tg_q    <= hit_tg;
						tval_q  <= 1'b0;
						pend_q  <= {1'b1, 1'b1, 1'b1, 4'b0000};
						fwd_q   <= 1'b0;
						vt_we_q <= 1'b0;
						for (int i = 0; i < MAX_COMBOS; i++) begin
							if (CNT_W'(i) == hit_r) begin
								active_q[i] <= 1'b0;
							end
						end
					end else begin
						// forwarded only if the press went out
						pend_q  <= PEND_VERDICT;
						fwd_q   <= in_map(code_q) && vt_rd0;
						vt_we_q <= 1'b1;
						vt_wd_q <= 1'b0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (push_fire) begin
						pend_q <= pend_q & ~lo;
						if (lo[P_VERDICT]) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bcc_outreg.sv
// Output register between the sequencer and the result channel.
// Depends on bcc_pkg for item_t.
`default_nettype none

module bcc_outreg import bcc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire item_t push_item,
	output logic       out_valid,
	input  wire logic  out_ready,
	output item_t      out_item
);

	logic  valid_q;
	item_t item_q;

	// refill in the same cycle the held beat leaves
	assign push_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_item   = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			item_q  <= '0;
		end else begin
			if (push_valid && push_ready) begin
				valid_q <= 1'b1;
				item_q  <= push_item;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bcc_checker.sv
// Port-level checks on the result channel of the combo engine, bound to
// the top level. Depends on bcc_pkg and button_chord_combo_engine_unit.
`default_nettype none

module bcc_checker import bcc_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [1:0]        item_kind,
	input wire logic [CODE_W-1:0] event_code,
	input wire logic              event_value,
	input wire logic              forward,
	input wire logic              last
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(item_kind) &&
		$stable(event_code) && $stable(event_value) && $stable(forward) && $stable(last))
		else $error("result beat changed while stalled");

	// only the verdict closes a run
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (item_kind == KIND_VERDICT)))
		else $error("last flag does not match verdict");

	// non-key beats carry no code, only the verdict carries forward
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind != KIND_KEY |-> event_code == '0 && !event_value &&
		(forward == 1'b0 || item_kind == KIND_VERDICT))
		else $error("stray payload on sync or verdict beat");

	// every extra key beat is followed at once by its sync
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && item_kind == KIND_KEY |=>
		out_valid && item_kind == KIND_SYNC)
		else $error("key beat not followed by sync");

endmodule

bind button_chord_combo_engine_unit bcc_checker u_bcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.item_kind   (item_kind),
	.event_code  (event_code),
	.event_value (event_value),
	.forward     (forward),
	.last        (last)
);

`default_nettype wire

FILE: sim/button_chord_combo_engine_unit_tb.sv
// Self-checking bench for button_chord_combo_engine_unit: a scoreboard class tracks
// held bitmaps and combo rules, predicts every result beat and checks them in order.
// Depends on bcc_pkg and the RTL top level only.
`timescale 1ns / 1ps

module button_chord_combo_engine_unit_tb;
	import bcc_pkg::*;

	localparam int MAX_COMBOS = 4;
	localparam int KEY_CODES  = 1024;
	localparam int CLK_PERIOD = 10;
	localparam int TIMEOUT_NS = 6_000_000;

	// key values beyond press are all autorepeat
	localparam logic [KV_W-1:0] KV_REPEAT    = 2'd2;
	localparam logic [KV_W-1:0] KV_REPEAT_HI = 2'd3;
	// first config index with no register behind it
	localparam int REG_FIRST_UNUSED = REG_RULE0 + RULE_REGS;
	// highest code the bitmaps cover
	localparam logic [CODE_W-1:0] TOP_CODE = CODE_W'(KEY_CODES - 1);

	// Scoreboard: own copy of the config and the held state, plus the queue of
	// result beats that accepted key events still owe.
	class combo_scoreboard;
		logic [CNT_W-1:0] rule_count;
		rule_t            rules [MAX_COMBOS];
		bit               phys_down [KEY_CODES];
		bit               pad_down [KEY_CODES];
		bit               combo_on [MAX_COMBOS];
		item_t            beats_due [$];
		int               errors;
		int               events_seen;
		int               beats_checked;
		int               combos_fired;

		function new();
			rule_count = '0;
			foreach (rules[i]) rules[i] = '0;
			errors = 0;
			events_seen = 0;
			beats_checked = 0;
			combos_fired = 0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			int slot;
			slot = int'(idx) - int'(REG_RULE0);
			if (idx == REG_COUNT) begin
				rule_count = data[CNT_W-1:0];
			end else if (slot >= 0 && slot < RULE_REGS && slot < MAX_COMBOS) begin
				rules[slot] = data;
			end
		endfunction

		function void queue_beat(input kind_t kind, input logic [CODE_W-1:0] code,
				input logic value, input logic fwd, input logic last_flag);
			item_t it;
			it.kind  = kind;
			it.code  = code;
			it.value = value;
			it.fwd   = fwd;
			it.last  = last_flag;
			beats_due = {beats_due, it};
		endfunction

		// extra key event is always followed by its sync report
		function void push_key(input logic [CODE_W-1:0] code, input logic value);
			queue_beat(KIND_KEY, code, value, 1'b0, 1'b0);
			queue_beat(KIND_SYNC, '0, 1'b0, 1'b0, 1'b0);
		endfunction

		function void note_event(input logic [CODE_W-1:0] code,
				input logic [KV_W-1:0] kv);
			int    lim;
			int    i;
			bit    hit;
			bit    consume;
			rule_t r;
			events_seen++;
			lim = (rule_count > MAX_COMBOS) ? MAX_COMBOS : int'(rule_count);
			hit = 1'b0;
			consume = 1'b0;
			if (lim == 0) begin
				// no rules: pass through, state untouched
				queue_beat(KIND_VERDICT, '0, 1'b0, 1'b1, 1'b1);
				return;
			end
			if (kv == KV_PRESS) begin
				phys_down[code] = 1'b1;
				for (i = 0; i < lim && !hit; i++) begin
					r = rules[i];
					if (!combo_on[i] && phys_down[r.b1] && phys_down[r.b2]) begin
						// recall sources still down on the pad, then press target
						if (pad_down[r.b1]) begin
							push_key(r.b1, 1'b0);
							pad_down[r.b1] = 1'b0;
						end
						if (pad_down[r.b2]) begin
							push_key(r.b2, 1'b0);
							pad_down[r.b2] = 1'b0;
						end
						push_key(r.tg, 1'b1);
						pad_down[r.tg] = 1'b1;
						combo_on[i] = 1'b1;
						hit = 1'b1;
						combos_fired++;
					end
				end
				if (hit)
					consume = 1'b1;
				else
					pad_down[code] = 1'b1;
			end else if (kv == KV_RELEASE) begin
				phys_down[code] = 1'b0;
				for (i = 0; i < lim && !hit; i++) begin
					r = rules[i];
					if (combo_on[i] && (code == r.b1 || code == r.b2)) begin
						push_key(r.tg, 1'b0);
						pad_down[r.tg] = 1'b0;
						combo_on[i] = 1'b0;
						hit = 1'b1;
					end
				end
				if (hit)
					consume = 1'b1;
				else if (pad_down[code])
					pad_down[code] = 1'b0;
				else
					consume = 1'b1;    // release that was never forwarded
			end else begin
				for (i = 0; i < lim; i++) begin
					r = rules[i];
					if (combo_on[i] && (code == r.b1 || code == r.b2))
						consume = 1'b1;
				end
			end
			queue_beat(KIND_VERDICT, '0, 1'b0, !consume, 1'b1);
		endfunction

		function void compare_field(input string field, input logic [CODE_W-1:0] want,
				input logic [CODE_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_beat(input logic [1:0] kind, input logic [CODE_W-1:0] code,
				input logic value, input logic fwd, input logic last_flag);
			item_t want;
			if (beats_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, got kind=%0d code=%0d",
					$time, kind, code);
				return;
			end
			want = beats_due.pop_front();
			beats_checked++;
			compare_field("item_kind", CODE_W'(want.kind), CODE_W'(kind));
			compare_field("event_code", want.code, code);
			compare_field("event_value", CODE_W'(want.value), CODE_W'(value));
			compare_field("forward", CODE_W'(want.fwd), CODE_W'(fwd));
			compare_field("last", CODE_W'(want.last), CODE_W'(last_flag));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [CODE_W-1:0]     key_code = '0;
	logic [KV_W-1:0]       key_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            item_kind;
	logic [CODE_W-1:0]     event_code;
	logic                  event_value;
	logic                  forward;
	logic                  last;

	combo_scoreboard sb = new();

	bit                allow_gaps = 1'b0;   // random idle bursts on both channels
	int                stall_left = 0;
	int                cfg_writes = 0;
	logic [CODE_W-1:0] button_pool [8];     // codes the current phase's rules draw on
	rule_t             phase_rules [MAX_COMBOS];

	button_chord_combo_engine_unit #(
		.MAX_COMBOS(MAX_COMBOS),
		.KEY_CODES (KEY_CODES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.key_code   (key_code),
		.key_value  (key_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.item_kind  (item_kind),
		.event_code (event_code),
		.event_value(event_value),
		.forward    (forward),
		.last       (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Receiver side: ready drops for bursts while gaps are allowed.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (allow_gaps && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 10);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result monitor: values seen here are the ones from before this edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat(item_kind, event_code, event_value, forward, last);
	end

	// Config beat; valid drops afterwards so two writes never share a step.
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One key event beat. Valid stays up into the next event unless a gap is taken.
	task automatic send_event(input logic [CODE_W-1:0] code, input logic [KV_W-1:0] kv);
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		key_code  <= code;
		key_value <= kv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_event(code, kv);
	endtask

	// Stop sending and let every owed beat arrive before touching config.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.beats_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [KV_W-1:0] any_repeat();
		return $urandom_range(0, 1) ? KV_REPEAT : KV_REPEAT_HI;
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		if ($urandom_range(0, 9) < 7)
			return button_pool[$urandom_range(0, 7)];
		return CODE_W'($urandom_range(0, KEY_CODES - 1));
	endfunction

	// Well-formed chord on one rule: both sources down, maybe a stray press, maybe a repeat, both up.
	task automatic play_chord(input rule_t r);
		logic [CODE_W-1:0] first_b;
		logic [CODE_W-1:0] second_b;
		if ($urandom_range(0, 1)) begin
			first_b = r.b1;
			second_b = r.b2;
		end else begin
			first_b = r.b2;
			second_b = r.b1;
		end
		send_event(first_b, KV_PRESS);
		if ($urandom_range(0, 4) == 0)
			send_event(pick_code(), KV_PRESS);   // stray press inside the chord
		send_event(second_b, KV_PRESS);
		if ($urandom_range(0, 2) == 0)
			send_event($urandom_range(0, 1) ? first_b : r.tg, any_repeat());
		if ($urandom_range(0, 1)) begin
			send_event(first_b, KV_RELEASE);
			send_event(second_b, KV_RELEASE);
		end else begin
			send_event(second_b, KV_RELEASE);
			send_event(first_b, KV_RELEASE);
		end
	endtask

	// Random phase: fresh rules from a small button pool, then chords and noise.
	task automatic run_phase(input int rules_used, input int n_events, input bit gaps);
		int target;
		int i;
		int sel;
		settle();
		allow_gaps = gaps;
		for (i = 0; i < $size(button_pool); i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 8)
				button_pool[i] = CODE_W'($urandom_range(0, 15));
			else if (sel == 8)
				button_pool[i] = TOP_CODE;
			else
				button_pool[i] = CODE_W'($urandom_range(0, KEY_CODES - 1));
		end
		for (i = 0; i < MAX_COMBOS; i++) begin
			phase_rules[i].b1 = button_pool[$urandom_range(0, 7)];
			phase_rules[i].b2 = button_pool[$urandom_range(0, 7)];
			phase_rules[i].tg = $urandom_range(0, 3) == 0 ? pick_code()
				: button_pool[$urandom_range(0, 7)];
			write_cfg(CFG_IDX_W'(int'(REG_RULE0) + i), phase_rules[i]);
		end
		if ($urandom_range(0, 2) == 0)
			write_cfg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1)),
				CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
		write_cfg(REG_COUNT, CFG_DATA_W'(rules_used));
		target = sb.events_seen + n_events;
		while (sb.events_seen < target) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				play_chord(phase_rules[$urandom_range(0, MAX_COMBOS - 1)]);
			end else if (sel < 8) begin
				send_event(pick_code(), KV_PRESS);
			end else if (sel < 9) begin
				send_event(pick_code(), KV_RELEASE);
			end else begin
				send_event(pick_code(), any_repeat());
			end
		end
	endtask

	initial begin
		int idx;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: no rules in use, everything passes through.
		write_cfg(REG_COUNT, 0);
		write_cfg(REG_RULE0, '0);
		send_event(TOP_CODE, KV_PRESS);
		send_event(0, KV_RELEASE);
		send_event(10'h2AA, KV_REPEAT_HI);
		settle();

		// Rules 0 and 2 chain (rule 0's target is a source of rule 2), rule 1
		// uses code extremes, rule 3 is all ones.
		write_cfg(REG_RULE0,        rule_t'{tg: 10'd4,   b2: 10'd2,    b1: 10'd1});
		write_cfg(REG_RULE0 + 3'd1, rule_t'{tg: 10'd0,   b2: 10'd1023, b1: 10'd0});
		write_cfg(REG_RULE0 + 3'd2, rule_t'{tg: 10'd200, b2: 10'd4,    b1: 10'd3});
		write_cfg(REG_RULE0 + 3'd3, '1);
		for (idx = REG_FIRST_UNUSED; idx < (1 << CFG_IDX_W); idx++)
			write_cfg(CFG_IDX_W'(idx), '1);   // no register there: must be dropped
		write_cfg(REG_COUNT, CFG_DATA_W'(MAX_COMBOS));

		send_event(1, KV_PRESS);              // forwarded, pad holds 1
		send_event(2, KV_PRESS);              // rule 0 fires, recalls 1, presses 4
		send_event(1, KV_REPEAT);             // repeat of active source: consumed
		send_event(9, KV_REPEAT_HI);          // unrelated repeat: forwarded
		send_event(3, KV_PRESS);              // no chord yet, pad holds 3
		send_event(4, KV_PRESS);              // rule 2 fires, recalls 3 and 4: longest run
		send_event(4, KV_RELEASE);            // releases 200
		send_event(3, KV_RELEASE);            // never forwarded: consumed
		send_event(1, KV_RELEASE);            // releases 4
		send_event(2, KV_RELEASE);
		send_event(0, KV_PRESS);
		send_event(TOP_CODE, KV_PRESS);       // rule 1 fires, target equals a source
		send_event(TOP_CODE, KV_RELEASE);
		send_event(0, KV_RELEASE);
		settle();

		// Oversized count clamps to the rules that exist.
		write_cfg(REG_COUNT, CFG_DATA_W'((1 << CNT_W) - 1));
		send_event(TOP_CODE, KV_PRESS);       // rule 3: both sources the same code
		send_event(TOP_CODE, KV_REPEAT);
		send_event(TOP_CODE, KV_RELEASE);
		settle();
		write_cfg(REG_COUNT, 0);
		send_event(5, KV_RELEASE);

		// Random phases over a range of rule counts, the third and the last without gaps.
		run_phase(4, 80, 1'b1);
		run_phase(2, 70, 1'b1);
		run_phase((1 << CNT_W) - 1, 60, 1'b0);
		run_phase(1, 50, 1'b1);
		run_phase(0, 20, 1'b1);
		run_phase(3, 60, 1'b1);
		run_phase(MAX_COMBOS, 80, 1'b0);

		settle();
		repeat (30) @(posedge clk);

		if (sb.beats_due.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d result beats never arrived", $time, sb.beats_due.size());
		end
		$display("Ran %0d key events through %0d config writes; %0d result beats checked.",
			sb.events_seen, cfg_writes, sb.beats_checked);
		$display("Chords fired %0d combos; rule counts went from none to oversized.",
			sb.combos_fired);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: covers the clearing pass and the slowest legal stall pattern many times.
	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timed out, %0d beats still owed", $time, sb.beats_due.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule
